>>> src/bitmap_block_allocator_core_macros.svh
// Assertion helpers for the allocator top level.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

  localparam int MAX_BITS_DEF = 1024;
  localparam int ACTIVE_W     = 11;
  localparam int ACTIVE_RESET = 1024;
  localparam int FUNC_W       = 3;
  localparam int INDEX_W      = 10;
  localparam int WORD_W       = 32;

  localparam logic [FUNC_W-1:0] FUNC_GET   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               bit_value;
    logic [INDEX_W-1:0] granted_index;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clr_step;
    logic rd_item;
    logic exec;
    logic scan_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic alloc_req;
    logic scan_done;
  } sts_t;

endpackage

>>> src/bba_ram.sv
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bba_ctrl.sv
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_SCAN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = sts.alloc_req ? ST_SCAN : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_item = 1'b1;
        state_next  = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> src/bba_datapath.sv
`timescale 1ns / 1ps
module bba_datapath #(
  parameter int MAX_BITS = bba_pkg::MAX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bba_pkg::req_t                  req,
  input  logic                           cfg_wr,
  input  logic [bba_pkg::ACTIVE_W-1:0]   cfg_data,
  input  bba_pkg::cmd_t                  cmd,
  output bba_pkg::sts_t                  sts,
  output logic                           done,
  output bba_pkg::rsp_t                  rsp
);

  localparam int MapWords = (MAX_BITS + 31) / 32;
  localparam int AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int CW       = (AW + 6 > 12) ? AW + 6 : 12;
  localparam int WW       = bba_pkg::WORD_W;
  localparam int LW       = bba_pkg::ACTIVE_W;
  localparam logic [LW-1:0] LimRst =
    LW'((bba_pkg::ACTIVE_RESET > MAX_BITS) ? MAX_BITS : bba_pkg::ACTIVE_RESET);

  bba_pkg::req_t req_q;
  logic [LW-1:0] lim;
  logic [AW-1:0] clr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] chk_ptr;
  logic          chk_vld;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  bba_ram #(.WIDTH(WW), .DEPTH(MapWords)) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // single-entry operations
  logic [AW-1:0] item_word;
  logic [4:0]    bit_sel;
  logic [WW-1:0] mask;
  logic          in_range;
  logic          in_limit;
  logic          exec_we;
  logic [WW-1:0] exec_wdata;
  bba_pkg::rsp_t exec_rsp;

  assign item_word = AW'(req_q.index >> 5);
  assign bit_sel   = req_q.index[4:0];
  assign mask      = 32'd1 << bit_sel;
  assign in_range  = ({22'd0, req_q.index} < 32'(MAX_BITS));
  assign in_limit  = ({1'b0, req_q.index} < lim);

  always_comb begin
    exec_we    = 1'b0;
    exec_wdata = ram_rdata;
    exec_rsp   = '0;
    unique case (req_q.func)
      bba_pkg::FUNC_GET: begin
        exec_rsp.bit_value = in_range & ram_rdata[bit_sel];
      end
      bba_pkg::FUNC_SET: begin
        exec_we    = in_range;
        exec_wdata = ram_rdata | mask;
      end
      bba_pkg::FUNC_CLEAR: begin
        exec_we    = in_range;
        exec_wdata = ram_rdata & ~mask;
      end
      bba_pkg::FUNC_FREE: begin
        exec_we         = in_limit;
        exec_wdata      = ram_rdata & ~mask;
        exec_rsp.status = ~in_limit;
      end
      default: begin
        exec_rsp.status = 1'b1;
      end
    endcase
  end

  // first-fit scan: lowest free bit of the word checked this cycle
  logic [WW-1:0] free_bits;
  logic          found;
  logic [4:0]    free_pos;
  logic [CW-1:0] base;
  logic [CW-1:0] pos;
  logic [CW-1:0] next_base;
  logic [CW-1:0] lim_x;
  logic          scan_done;
  logic          scan_hit;
  bba_pkg::rsp_t scan_rsp;

  assign free_bits = ~ram_rdata;
  assign found     = |free_bits;

  always_comb begin
    free_pos = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_pos = 5'(i);
      end
    end
  end

  assign base      = CW'({chk_ptr, 5'b00000});
  assign pos       = base + CW'(free_pos);
  assign next_base = base + CW'(WW);
  assign lim_x     = CW'(lim);
  assign scan_hit  = chk_vld & found & (pos < lim_x);
  assign scan_done = chk_vld & (found | (next_base >= lim_x));

  always_comb begin
    scan_rsp               = '0;
    scan_rsp.status        = ~scan_hit;
    scan_rsp.granted_index = scan_hit ? bba_pkg::INDEX_W'(pos) : '0;
  end

  // map port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_word;
    ram_wdata = exec_wdata;
    priority if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_ptr;
      ram_wdata = '0;
    end else if (cmd.exec) begin
      ram_we = exec_we;
    end else if (cmd.scan_step) begin
      ram_we    = scan_hit;
      ram_waddr = chk_ptr;
      ram_wdata = ram_rdata | (32'd1 << free_pos);
    end
  end

  assign ram_raddr = cmd.rd_item ? item_word : rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim     <= LimRst;
      clr_ptr <= '0;
      rd_ptr  <= '0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        lim <= ({21'd0, cfg_data} > 32'(MAX_BITS)) ? LW'(MAX_BITS) : cfg_data;
      end
      if (cmd.clr_step) begin
        clr_ptr <= clr_ptr + AW'(1);
      end
      if (cmd.capture) begin
        rd_ptr  <= '0;
        chk_vld <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_ptr  <= rd_ptr + AW'(1);
        chk_vld <= ~scan_done;
      end
      done <= cmd.exec | (cmd.scan_step & scan_done);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.scan_step) begin
      chk_ptr <= rd_ptr;
    end
    if (cmd.exec) begin
      rsp <= exec_rsp;
    end else if (cmd.scan_step & scan_done) begin
      rsp <= scan_rsp;
    end
  end

  assign sts.clr_last  = (clr_ptr == AW'(MapWords - 1));
  assign sts.alloc_req = (req.func == bba_pkg::FUNC_ALLOC);
  assign sts.scan_done = scan_done;

endmodule

>>> src/bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
// Channel   Handshake              Word
// request   start & !busy          req  (func, index)
// config    cfg_valid & cfg_ready  cfg_data (active_bits)
// result    done, one cycle only   rsp  (status, bit_value, granted_index)
//
// Get, set, clear, free: read the map word, modify and write it back, then strobe
//   the result; the next request is taken while done shows.
// Allocate: the scan ends at the first map word with a free bit or at the active size;
//   the map RAM streams one 32-bit word per cycle into the checker.
// After reset the map RAM is cleared one word per cycle with busy high; config writes
//   are taken throughout; the result strobe never stalls.
`include "bitmap_block_allocator_core_macros.svh"

module bitmap_block_allocator_core #(
  parameter int MAX_BITS = bba_pkg::MAX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  bba_pkg::req_t                 req,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bba_pkg::ACTIVE_W-1:0]  cfg_data,
  // result channel
  output logic                          done,
  output bba_pkg::rsp_t                 rsp
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  // The size register takes a write at any time.
  assign cfg_ready = 1'b1;

  // Sequence clearing, single-entry operations and the first-fit scan.
  bba_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  // Hold the map RAM, the size limit, the scan pointers and the result word.
  bba_datapath #(.MAX_BITS(MAX_BITS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg_wr  (cfg_valid & cfg_ready),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .done    (done),
    .rsp     (rsp)
  );

  // An accepted request keeps the block busy in the next cycle.
  `BBA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted request not busy")
  // Results never come back to back: every operation needs a map read first.
  `BBA_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe on two cycles")
  // A granted index only comes with success.
  `BBA_ASSERT_IMPL(a_grant_ok, clk, rst, done && (rsp.granted_index != '0),
    rsp.status == 1'b0, "granted index with failure status")
  // A bit read never travels with a grant or a failure.
  `BBA_ASSERT_IMPL(a_bit_alone, clk, rst, done && rsp.bit_value,
    (rsp.status == 1'b0) && (rsp.granted_index == '0), "bit value mixed with other fields")

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_block_allocator_core.
module tb;
  import bba_pkg::*;

  localparam int MAX_BITS       = MAX_BITS_DEF;
  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int MAX_GAP        = 13;
  // Falling edges the driver waits with no response outstanding before a size write.
  localparam int CFG_SETTLE     = 4;
  // Keep the tail comfortably past the longest allocate search.
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PRINT_CAP      = 40;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 90;
  localparam int FILL_ITEMS     = MAX_BITS + 2;

  // Operation codes the block leaves unused.
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;

  typedef enum int {ITEM_REQ, ITEM_CFG, ITEM_DRAIN} item_kind_e;

  typedef struct {
    item_kind_e          kind;
    req_t                req;
    logic [ACTIVE_W-1:0] cfg;
    int                  gap;
  } stim_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  req_t                req = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ACTIVE_W-1:0] cfg_data = '0;
  logic                done;
  rsp_t                rsp;

  bitmap_block_allocator_core #(
    .MAX_BITS(MAX_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .done     (done),
    .rsp      (rsp)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Shadow copy of the allocation map and of the active size register.
  bit [MAX_BITS-1:0]   used_map;
  logic [ACTIVE_W-1:0] active_size;

  // Responses predicted for accepted requests, oldest first.
  rsp_t       outstanding_rsp[$];
  // Requests, size writes and drain points waiting to be driven.
  stim_item_t stim_q[$];

  int  mismatches = 0;
  int  n_requests = 0;
  int  n_grants = 0;
  int  n_alloc_refused = 0;
  int  n_free_refused = 0;
  int  n_size_writes = 0;
  int  idle_cycles = 0;

  // Handshake flags seen at the last rising edge, read by the driver.
  bit  req_fire = 1'b0;
  bit  cfg_fire = 1'b0;

  // Driver state.
  bit         have_item = 1'b0;
  stim_item_t cur_item;
  int         wait_left = 0;
  int         settle_cnt = 0;
  bit         no_idle = 1'b0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Apply one request to the shadow map and return the response it must give.
  function automatic rsp_t predict_alloc_rsp(input req_t r);
    rsp_t o;
    int   lim;
    int   slot;
    int   i;
    o = '0;
    lim = (active_size > MAX_BITS) ? MAX_BITS : int'(active_size);
    case (r.func)
      FUNC_GET: begin
        o.bit_value = used_map[r.index];
      end
      FUNC_SET: begin
        used_map[r.index] = 1'b1;
      end
      FUNC_CLEAR: begin
        used_map[r.index] = 1'b0;
      end
      FUNC_ALLOC: begin
        // First fit: lowest free entry below the active size.
        slot = -1;
        for (i = 0; i < lim && slot < 0; i++) begin
          if (!used_map[i]) slot = i;
        end
        if (slot < 0) begin
          o.status = 1'b1;
        end else begin
          used_map[slot] = 1'b1;
          o.granted_index = slot[INDEX_W-1:0];
        end
      end
      FUNC_FREE: begin
        if (int'(r.index) < lim) used_map[r.index] = 1'b0;
        else o.status = 1'b1;
      end
      default: begin
        o.status = 1'b1;
      end
    endcase
    return o;
  endfunction

  // Monitor: sample at the rising edge, check the result word first since it
  // belongs to an earlier request, then predict for a request taken at this edge.
  always @(posedge clk) begin : monitor
    rsp_t exp;
    rsp_t pred;
    if (rst) begin
      used_map    = '0;
      active_size = ACTIVE_W'(ACTIVE_RESET);
      outstanding_rsp.delete();
      req_fire    = 1'b0;
      cfg_fire    = 1'b0;
      idle_cycles = 0;
    end else begin
      req_fire = start && !busy;
      cfg_fire = cfg_valid && cfg_ready;
      if (done) begin
        if (outstanding_rsp.size() == 0) begin
          report_mismatch($sformatf("result word with no request outstanding: %p", rsp));
        end else begin
          exp = outstanding_rsp.pop_front();
          if (rsp.status !== exp.status)
            report_mismatch($sformatf("status %b, expected %b", rsp.status, exp.status));
          if (rsp.bit_value !== exp.bit_value)
            report_mismatch($sformatf("bit_value %b, expected %b",
                                      rsp.bit_value, exp.bit_value));
          if (rsp.granted_index !== exp.granted_index)
            report_mismatch($sformatf("granted_index %0d, expected %0d",
                                      rsp.granted_index, exp.granted_index));
        end
      end
      if (cfg_fire) begin
        active_size = cfg_data;
        n_size_writes++;
      end
      if (req_fire) begin
        pred = predict_alloc_rsp(req);
        outstanding_rsp.push_back(pred);
        n_requests++;
        if (req.func == FUNC_ALLOC) begin
          if (pred.status) n_alloc_refused++;
          else n_grants++;
        end
        if (req.func == FUNC_FREE && pred.status) n_free_refused++;
      end
      // Watchdog: count edges at which no word moves on any channel.
      if (req_fire || cfg_fire || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Driver: change inputs at the falling edge. Drop start or cfg_valid once the
  // word was taken, then serve the next queued item after its drawn gap. Each
  // strobe gets exactly one nonblocking assignment per edge.
  always @(negedge clk) begin : driver
    logic nxt_start;
    logic nxt_cfg;
    nxt_start = start;
    nxt_cfg   = cfg_valid;
    if (rst) begin
      nxt_start  = 1'b0;
      nxt_cfg    = 1'b0;
      settle_cnt = 0;
    end else begin
      if (start && req_fire) nxt_start = 1'b0;
      if (cfg_valid && cfg_fire) nxt_cfg = 1'b0;
      if (outstanding_rsp.size() == 0) settle_cnt++;
      else settle_cnt = 0;
      if (!nxt_start && !nxt_cfg) begin
        if (!have_item && stim_q.size() > 0) begin
          cur_item  = stim_q.pop_front();
          have_item = 1'b1;
          wait_left = cur_item.gap;
        end
        if (have_item) begin
          if (wait_left > 0) begin
            wait_left--;
          end else begin
            case (cur_item.kind)
              ITEM_REQ: begin
                nxt_start = 1'b1;
                req       <= cur_item.req;
                have_item = 1'b0;
              end
              ITEM_CFG: begin
                // Write the size only with no response outstanding and the wait settled.
                if (settle_cnt >= CFG_SETTLE) begin
                  nxt_cfg   = 1'b1;
                  cfg_data  <= cur_item.cfg;
                  have_item = 1'b0;
                end
              end
              ITEM_DRAIN: begin
                // Hold off until every predicted response has come back.
                if (outstanding_rsp.size() == 0) have_item = 1'b0;
              end
              default: have_item = 1'b0;
            endcase
          end
        end
      end
    end
    start     <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(MAX_GAP, 0));
  endfunction

  task automatic push_req(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx);
    stim_item_t it;
    it.kind      = ITEM_REQ;
    it.req.func  = f;
    it.req.index = idx;
    it.cfg       = '0;
    it.gap       = draw_gap();
    stim_q.push_back(it);
  endtask

  task automatic push_size(input logic [ACTIVE_W-1:0] v);
    stim_item_t it;
    it.kind = ITEM_CFG;
    it.req  = '0;
    it.cfg  = v;
    it.gap  = draw_gap();
    stim_q.push_back(it);
  endtask

  task automatic push_drain();
    stim_item_t it;
    it.kind = ITEM_DRAIN;
    it.req  = '0;
    it.cfg  = '0;
    it.gap  = 0;
    stim_q.push_back(it);
  endtask

  // Size settings for the random phases: edges around word boundaries, zero,
  // saturation above the store, and the odd random size.
  function automatic logic [ACTIVE_W-1:0] pick_active_size();
    case ($urandom_range(11, 0))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd2;
      3:       return 11'd31;
      4:       return 11'd32;
      5:       return 11'd33;
      6:       return 11'd100;
      7:       return 11'd1023;
      8:       return 11'd1024;
      9:       return 11'd2047;
      default: return ACTIVE_W'($urandom_range(1024, 1));
    endcase
  endfunction

  // Mostly land inside (or one past) the active size; sometimes anywhere.
  function automatic logic [INDEX_W-1:0] pick_index(input int lim);
    int hi;
    hi = (lim > MAX_BITS - 1) ? MAX_BITS - 1 : lim;
    if ($urandom_range(3, 0) != 0) return INDEX_W'($urandom_range(hi, 0));
    return INDEX_W'($urandom_range(MAX_BITS - 1, 0));
  endfunction

  task automatic push_random_phase(input int count);
    logic [ACTIVE_W-1:0] sz;
    int                  lim;
    int                  sel;
    int                  k;
    sz = pick_active_size();
    lim = (sz > MAX_BITS) ? MAX_BITS : int'(sz);
    no_idle = ($urandom_range(3, 0) == 0);
    push_size(sz);
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(99, 0);
      if (sel < 35)      push_req(FUNC_ALLOC, INDEX_W'($urandom));
      else if (sel < 60) push_req(FUNC_FREE, pick_index(lim));
      else if (sel < 75) push_req(FUNC_GET, pick_index(lim));
      else if (sel < 85) push_req(FUNC_SET, pick_index(lim));
      else if (sel < 95) push_req(FUNC_CLEAR, pick_index(lim));
      else push_req(FUNC_W'($urandom_range(FUNC_RSVD_HI, FUNC_RSVD_LO)), INDEX_W'($urandom));
      // Now and then let everything drain before carrying on.
      if ($urandom_range(49, 0) == 0) push_drain();
      // Switch between idling and back-to-back stretches within a phase.
      if ($urandom_range(29, 0) == 0) no_idle = !no_idle;
    end
  endtask

  initial begin : stimulus
    int p;
    int k;

    // Directed: fresh map, both ends of the index range, every operation.
    push_size(11'd1024);
    push_req(FUNC_GET, 10'd0);
    push_req(FUNC_GET, 10'd1023);
    push_req(FUNC_SET, 10'd1023);
    push_req(FUNC_GET, 10'd1023);
    push_req(FUNC_SET, 10'd0);
    push_req(FUNC_GET, 10'd0);
    push_req(FUNC_CLEAR, 10'd0);
    push_req(FUNC_GET, 10'd0);
    push_req(FUNC_ALLOC, 10'd1023);
    push_req(FUNC_ALLOC, 10'd0);
    push_req(FUNC_FREE, 10'd1);
    push_req(FUNC_FREE, 10'd1023);
    push_req(FUNC_GET, 10'd1023);
    push_req(FUNC_RSVD_LO, 10'd1023);
    push_req(FUNC_W'(FUNC_RSVD_LO + 3'd1), 10'd0);
    push_req(FUNC_RSVD_HI, 10'd1023);
    // One-entry map: full map refuses, free at the size refuses.
    push_size(11'd1);
    push_req(FUNC_ALLOC, 10'd0);
    push_req(FUNC_FREE, 10'd1);
    push_req(FUNC_FREE, 10'd0);
    push_req(FUNC_ALLOC, 10'd0);
    push_req(FUNC_ALLOC, 10'd0);
    // Zero size: allocate and free refuse; get still reads.
    push_size(11'd0);
    push_req(FUNC_ALLOC, 10'd0);
    push_req(FUNC_FREE, 10'd0);
    push_req(FUNC_GET, 10'd0);
    // Size above the store saturates.
    push_size(11'd2047);
    push_req(FUNC_ALLOC, 10'd0);
    push_req(FUNC_FREE, 10'd1023);
    push_drain();

    for (p = 0; p < RAND_PHASES; p++) begin
      push_random_phase(PHASE_ITEMS);
      if (p == RAND_PHASES / 2 - 1) begin
        // Fill the whole map by allocation, pushing the search to the last
        // word, then run into the full map.
        no_idle = 1'b1;
        push_size(11'd1024);
        for (k = 0; k < FILL_ITEMS; k++) begin
          if ($urandom_range(15, 0) == 0) no_idle = !no_idle;
          push_req(FUNC_ALLOC, INDEX_W'($urandom));
        end
        push_req(FUNC_GET, 10'd1023);
        push_drain();
      end
    end
    push_size(11'd1024);

    // Reset once, released at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the queue to empty and every response to come home.
    while (stim_q.size() != 0 || have_item || start || cfg_valid ||
           outstanding_rsp.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (outstanding_rsp.size() != 0) report_mismatch("responses still outstanding at end");

    $display("covered %0d requests: %0d grants, %0d refused allocates, %0d refused frees",
             n_requests, n_grants, n_alloc_refused, n_free_refused);
    $display("across %0d size writes, %0d mismatches", n_size_writes, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
